[rtl/pal_pkg.sv]
package pal_pkg;

  localparam int DEFAULT_DEPTH = 128;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_LOCATE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
  } result_t;

endpackage

[rtl/positional_array_list.sv]
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------------
// item     | item_valid   | item_stall   | item   : cmd, position, value
// result   | result_valid | result_stall | result : ok, read_value, found_position,
//          |              |              |          list_length
//
// one request at a time; insert, delete and locate walk the store one entry a cycle, and a new
// request is taken only once the result of the last one is loaded; a locate hit ends the
// scan early, and get reads its single entry
// rst is synchronous and clears the length count and the control state; the entry store
// keeps its contents, and only entries below the length are ever read
// item_stall is high from acceptance until the result is loaded; a waiting result holds FINISH
module positional_array_list #(
  parameter int DEPTH = pal_pkg::DEFAULT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pal_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output pal_pkg::result_t result
);

  // address, count and position widths
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int PW = LW + 1;
  localparam int FW = (AW + 1 > 8) ? AW + 1 : 8;

  // one-hot sequencer states
  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    WALK   = 3'b010,
    FINISH = 3'b100
  } state_t;

  state_t         state;
  pal_pkg::item_t req;          // request being worked on
  logic [CW-1:0]  count;        // list length
  logic [AW-1:0]  addr;         // next entry to read
  logic [CW-1:0]  left;         // reads still to issue
  logic           pend;         // read data arrives this cycle
  logic [AW-1:0]  pend_addr;    // entry that read data came from

  logic               res_ok;
  logic signed [31:0] res_rd;
  logic [7:0]         res_found;

  // entry store, one write and one registered read per cycle
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mem_rd;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;
  logic               mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= mem[addr];
    end
  end

  logic          accept;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          pos_nz;
  logic          walk_done;
  logic          hit;
  logic [FW-1:0] hit_pos;
  logic [LW-1:0] len_w;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign pos_w      = PW'(item.position);
  assign cnt_w      = PW'(count);
  assign pos_nz     = (item.position != 8'd0);
  assign walk_done  = (left == '0) && !pend;
  assign hit        = pend && (req.cmd == pal_pkg::CMD_LOCATE) && (mem_rd == req.value);
  assign hit_pos    = FW'(pend_addr) + FW'(1);
  assign len_w      = LW'(count);

  // reads come ahead of the shifted writes, so no entry is read and written in one cycle
  always_comb begin
    mem_re = (state == WALK) && (left != '0) && !hit;
    mem_we = 1'b0;
    mem_wa = pend_addr;
    mem_wd = mem_rd;
    if (state == WALK) begin
      if (pend) begin
        case (req.cmd)
          pal_pkg::CMD_INSERT: begin
            mem_we = 1'b1;
            mem_wa = pend_addr + AW'(1);
          end
          pal_pkg::CMD_DELETE: begin
            mem_we = 1'b1;
            mem_wa = pend_addr - AW'(1);
          end
          default: mem_we = 1'b0;
        endcase
      end else if (walk_done && req.cmd == pal_pkg::CMD_INSERT) begin
        // the new word drops into the gap left by the shift
        mem_we = 1'b1;
        mem_wa = AW'(PW'(req.position) - PW'(1));
        mem_wd = req.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      count        <= '0;
      left         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            req       <= item;
            res_ok    <= 1'b0;
            res_rd    <= '0;
            res_found <= '0;
            pend      <= 1'b0;
            left      <= '0;
            state     <= FINISH;
            case (item.cmd)
              pal_pkg::CMD_INSERT: begin
                if (pos_nz && pos_w <= cnt_w + PW'(1) && cnt_w < PW'(DEPTH)) begin
                  // move entries count-1 down to position-1 up by one
                  left  <= CW'(cnt_w + PW'(1) - pos_w);
                  addr  <= AW'(cnt_w - PW'(1));
                  state <= WALK;
                end
              end
              pal_pkg::CMD_DELETE: begin
                if (pos_nz && pos_w <= cnt_w) begin
                  // move entries position up to count-1 down by one
                  left  <= CW'(cnt_w - pos_w);
                  addr  <= AW'(pos_w);
                  state <= WALK;
                end
              end
              pal_pkg::CMD_GET: begin
                if (pos_nz && pos_w <= cnt_w) begin
                  left  <= CW'(1);
                  addr  <= AW'(pos_w - PW'(1));
                  state <= WALK;
                end
              end
              pal_pkg::CMD_LOCATE: begin
                left  <= count;
                addr  <= '0;
                state <= WALK;
              end
              pal_pkg::CMD_CLEAR: begin
                count  <= '0;
                res_ok <= 1'b1;
              end
              default: res_ok <= 1'b0;
            endcase
          end
        end
        WALK: begin
          if (mem_re) begin
            pend_addr <= addr;
            left      <= left - CW'(1);
            pend      <= 1'b1;
            if (req.cmd == pal_pkg::CMD_INSERT) begin
              addr <= addr - AW'(1);
            end else begin
              addr <= addr + AW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend && req.cmd == pal_pkg::CMD_GET) begin
            res_rd <= mem_rd;
            res_ok <= 1'b1;
          end
          if (hit) begin
            // first match ends the scan
            res_found <= hit_pos[7:0];
            res_ok    <= 1'b1;
            left      <= '0;
            pend      <= 1'b0;
            state     <= FINISH;
          end else if (walk_done) begin
            case (req.cmd)
              pal_pkg::CMD_INSERT: begin
                count  <= count + CW'(1);
                res_ok <= 1'b1;
              end
              pal_pkg::CMD_DELETE: begin
                count  <= count - CW'(1);
                res_ok <= 1'b1;
              end
              default: res_ok <= res_ok;
            endcase
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // result payload is loaded only from the finish step
  always_ff @(posedge clk) begin
    if (state == FINISH && (!result_valid || !result_stall)) begin
      result.ok             <= res_ok;
      result.read_value     <= res_rd;
      result.found_position <= res_found;
      result.list_length    <= len_w[7:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list length beyond store depth");

  a_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == WALK))
    else $error("store written outside a walk");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_wa) <= count))
    else $error("store write past the list end");

  a_pend_after_walk: assert property (@(posedge clk) disable iff (rst)
    pend |-> ($past(state) == WALK))
    else $error("read data pending outside a walk");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && !(result_valid && result_stall)) |=> (result_valid && state == IDLE))
    else $error("finished request not loaded into the output register");
`endif

endmodule
